// File: hw/rtl/zcobs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zcobs_pkg
// Shared types, register indexes, field widths and reset values for the
// three-phase zero-crossing observer.
// ----------------------------------------------------------------------------
package zcobs_pkg;

  localparam int ANGLE_BITS_DEF  = 12;
  localparam int WINDOW_BITS_DEF = 10;

  localparam int SAMPLE_W  = 16;
  localparam int MAG_W     = 17;
  localparam int POL_W     = 2;
  localparam int LEVEL_W   = 16;
  localparam int LEVEL_SHIFT = 15;

  localparam int STEP_W    = 8;
  localparam int ANGLE_CFG_W = 12;
  localparam int WLEN_W    = 11;
  localparam int SCALE_W   = 16;
  localparam int TIMEOUT_W = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_ANGLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_FLOOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_CEIL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_SCALE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_ANGLE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 3'd6;

  localparam logic [STEP_W-1:0]      STEP_ANGLE_RST  = 8'd1;
  localparam logic [ANGLE_CFG_W-1:0] ANGLE_FLOOR_RST = 12'd0;
  localparam logic [ANGLE_CFG_W-1:0] ANGLE_CEIL_RST  = 12'd360;
  localparam logic [WLEN_W-1:0]      WINDOW_LEN_RST  = 11'd360;
  localparam logic [SCALE_W-1:0]     LEVEL_SCALE_RST = 16'd32768;
  localparam logic [ANGLE_CFG_W-1:0] CHECK_ANGLE_RST = 12'd90;
  localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RST     = 16'd100;

  typedef logic signed [POL_W-1:0] pol_t;

  localparam pol_t POL_ZERO = 2'sb00;
  localparam pol_t POL_POS  = 2'sb01;
  localparam pol_t POL_NEG  = 2'sb11;

  typedef struct packed {
    pol_t pol;
    logic done;
  } phase_flags_t;

endpackage

// File: hw/rtl/zcobs_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zcobs_in_if
// Sample channel: one signed sample per phase per transfer.
// ----------------------------------------------------------------------------
interface zcobs_in_if;
  logic valid;
  logic ready;
  logic signed [zcobs_pkg::SAMPLE_W-1:0] sample_r;
  logic signed [zcobs_pkg::SAMPLE_W-1:0] sample_s;
  logic signed [zcobs_pkg::SAMPLE_W-1:0] sample_t;

  modport source (output valid, output sample_r, output sample_s, output sample_t,
                  input ready);
  modport sink (input valid, input sample_r, input sample_s, input sample_t,
                output ready);
endinterface

// File: hw/rtl/zcobs_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zcobs_out_if
// Result channel: polarities, window levels and adopted rotation.
// ----------------------------------------------------------------------------
interface zcobs_out_if;
  logic valid;
  logic ready;
  zcobs_pkg::pol_t polarity_r;
  zcobs_pkg::pol_t polarity_s;
  zcobs_pkg::pol_t polarity_t;
  logic [zcobs_pkg::LEVEL_W-1:0] level_r;
  logic [zcobs_pkg::LEVEL_W-1:0] level_s;
  logic [zcobs_pkg::LEVEL_W-1:0] level_t;
  zcobs_pkg::pol_t rotation;

  modport source (output valid, output polarity_r, output polarity_s, output polarity_t,
                  output level_r, output level_s, output level_t, output rotation,
                  input ready);
  modport sink (input valid, input polarity_r, input polarity_s, input polarity_t,
                input level_r, input level_s, input level_t, input rotation,
                output ready);
endinterface

// File: hw/rtl/zcobs_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zcobs_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface zcobs_cfg_if;
  logic valid;
  logic ready;
  logic [zcobs_pkg::CFG_IDX_W-1:0]  index;
  logic [zcobs_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/zcobs_phase.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zcobs_phase
// Per-phase angle tracking, crossing polarity and windowed magnitude sum.
// ----------------------------------------------------------------------------
module zcobs_phase #(
  parameter int ANGLE_BITS  = zcobs_pkg::ANGLE_BITS_DEF,
  parameter int WINDOW_BITS = zcobs_pkg::WINDOW_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     load,
  input  logic signed [zcobs_pkg::SAMPLE_W-1:0]    sample,
  input  logic [zcobs_pkg::STEP_W-1:0]             step_angle,
  input  logic [zcobs_pkg::ANGLE_CFG_W-1:0]        angle_floor,
  input  logic [zcobs_pkg::ANGLE_CFG_W-1:0]        angle_ceil,
  input  logic [zcobs_pkg::WLEN_W-1:0]             window_len,
  output zcobs_pkg::phase_flags_t                  flags,
  output logic [ANGLE_BITS-1:0]                    angle,
  output logic [WINDOW_BITS+15:0]                  sum_done
);

  localparam int SUM_W  = WINDOW_BITS + 16;
  localparam int CNT_W  = WINDOW_BITS + 1;
  localparam int CMP_W  = ((ANGLE_BITS > zcobs_pkg::ANGLE_CFG_W) ?
                           ANGLE_BITS : zcobs_pkg::ANGLE_CFG_W) + 1;
  localparam int WCMP_W = (CNT_W > zcobs_pkg::WLEN_W) ? CNT_W : zcobs_pkg::WLEN_W;

  logic                             last_sign;
  zcobs_pkg::pol_t                  pol;
  logic [SUM_W-1:0]                 sum;
  logic [CNT_W-1:0]                 cnt;
  logic                             done;

  logic                             neg;
  logic [zcobs_pkg::MAG_W-1:0]      mag;
  logic [CMP_W-1:0]                 angle_step;
  logic [CMP_W-1:0]                 ceil_ext;
  logic [ANGLE_BITS-1:0]            angle_next;
  zcobs_pkg::pol_t                  pol_next;
  logic [SUM_W-1:0]                 sum_acc;
  logic [CNT_W-1:0]                 cnt_inc;
  logic                             done_next;

  assign neg        = sample[zcobs_pkg::SAMPLE_W-1];
  assign mag        = neg ? zcobs_pkg::MAG_W'(17'h10000 - {1'b0, sample}) :
                            {1'b0, sample};
  assign angle_step = CMP_W'(angle) + CMP_W'(step_angle);
  assign ceil_ext   = CMP_W'(angle_ceil);
  assign sum_acc    = sum + SUM_W'(mag);
  assign cnt_inc    = cnt + CNT_W'(1);
  assign done_next  = WCMP_W'(cnt_inc) >= WCMP_W'(window_len);

  always_comb begin
    pol_next   = pol;
    angle_next = angle_step[ANGLE_BITS-1:0];
    if (neg != last_sign) begin
      if (angle_step < CMP_W'(angle_floor)) begin
        pol_next = zcobs_pkg::POL_ZERO;
      end else if (!neg) begin
        pol_next = zcobs_pkg::POL_POS;
      end else begin
        pol_next = zcobs_pkg::POL_NEG;
      end
      angle_next = '0;
    end else if (angle_step > ceil_ext) begin
      pol_next   = zcobs_pkg::POL_ZERO;
      angle_next = ceil_ext[ANGLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle     <= '0;
      last_sign <= 1'b0;
      pol       <= zcobs_pkg::POL_ZERO;
      sum       <= '0;
      cnt       <= '0;
      done      <= 1'b0;
    end else if (load) begin
      angle     <= angle_next;
      last_sign <= neg;
      pol       <= pol_next;
      done      <= done_next;
      if (done_next) begin
        sum <= '0;
        cnt <= '0;
      end else begin
        sum <= sum_acc;
        cnt <= cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum_done <= sum_acc;
    end
  end

  assign flags.pol  = pol;
  assign flags.done = done;

endmodule

// File: hw/rtl/zcobs_level.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zcobs_level
// Scale a finished window sum and saturate it to the level width.
// ----------------------------------------------------------------------------
module zcobs_level #(
  parameter int WINDOW_BITS = zcobs_pkg::WINDOW_BITS_DEF
) (
  input  logic [WINDOW_BITS+15:0]           sum,
  input  logic [zcobs_pkg::SCALE_W-1:0]     level_scale,
  output logic [zcobs_pkg::LEVEL_W-1:0]     level
);

  localparam int SUM_W  = WINDOW_BITS + 16;
  localparam int PROD_W = SUM_W + zcobs_pkg::SCALE_W;
  localparam int LO     = zcobs_pkg::LEVEL_SHIFT;
  localparam int HI     = zcobs_pkg::LEVEL_SHIFT + zcobs_pkg::LEVEL_W;

  logic [PROD_W-1:0] prod;

  assign prod  = PROD_W'(sum) * PROD_W'(level_scale);
  assign level = (|prod[PROD_W-1:HI]) ? {zcobs_pkg::LEVEL_W{1'b1}} : prod[HI-1:LO];

endmodule

// File: hw/rtl/zcobs_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zcobs_seq
// Phase sequence check with debounce of the candidate rotation.
// ----------------------------------------------------------------------------
module zcobs_seq #(
  parameter int ANGLE_BITS = zcobs_pkg::ANGLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  zcobs_pkg::pol_t                     pol_r,
  input  zcobs_pkg::pol_t                     pol_s,
  input  zcobs_pkg::pol_t                     pol_t,
  input  logic [ANGLE_BITS-1:0]               angle_r,
  input  logic [zcobs_pkg::ANGLE_CFG_W-1:0]   check_angle,
  input  logic [zcobs_pkg::TIMEOUT_W-1:0]     timeout,
  output zcobs_pkg::pol_t                     rotation
);

  localparam int CW = (ANGLE_BITS > zcobs_pkg::ANGLE_CFG_W) ?
                      ANGLE_BITS : zcobs_pkg::ANGLE_CFG_W;

  zcobs_pkg::pol_t                    candidate;
  logic [zcobs_pkg::TIMEOUT_W-1:0]    debounce;
  zcobs_pkg::pol_t                    dir;
  logic                               check;
  logic [zcobs_pkg::TIMEOUT_W-1:0]    debounce_inc;

  assign check = (pol_r == zcobs_pkg::POL_POS) && (CW'(angle_r) == CW'(check_angle));
  assign debounce_inc = debounce + zcobs_pkg::TIMEOUT_W'(1);

  always_comb begin
    dir = zcobs_pkg::POL_ZERO;
    if (pol_s == zcobs_pkg::POL_POS && pol_t == zcobs_pkg::POL_NEG) begin
      dir = zcobs_pkg::POL_NEG;
    end else if (pol_s == zcobs_pkg::POL_NEG && pol_t == zcobs_pkg::POL_POS) begin
      dir = zcobs_pkg::POL_POS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      candidate <= zcobs_pkg::POL_ZERO;
      debounce  <= '0;
      rotation  <= zcobs_pkg::POL_ZERO;
    end else if (load && check) begin
      if (dir != candidate) begin
        candidate <= dir;
        debounce  <= '0;
      end else if (debounce_inc >= timeout) begin
        rotation <= dir;
        debounce <= '0;
      end else begin
        debounce <= debounce_inc;
      end
    end
  end

endmodule

// File: hw/rtl/three_phase_zero_cross_observer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_phase_zero_cross_observer
// Zero-crossing polarity, windowed level and rotation detection for R, S, T.
//
// Channels: sample_ch carries one signed sample per phase; result_ch returns
// exactly one result per sample (polarities, levels of the last completed
// window, adopted rotation); cfg_ch writes the seven setting registers and
// is ready whenever reset is low. Write settings only while no sample is in
// flight.
// Pipeline: a transferred sample first goes through stage one, which updates
// the per-phase angle, polarity and window sum; stage two then registers the
// result, applying the level multiplier and the sequence debounce.
// Throughput: one sample per cycle while the result channel is not stalled,
// limited by the single update of each per-phase state per transfer.
// Stall: each stage holds while the next one is full and blocked, so the
// block keeps taking samples until both stages hold a result.
// Reset: all tracking state clears, settings return to defaults, both
// stages empty; sample_ch and cfg_ch hold ready low during reset and raise
// it as soon as reset drops.
// ----------------------------------------------------------------------------
module three_phase_zero_cross_observer #(
  parameter int ANGLE_BITS  = zcobs_pkg::ANGLE_BITS_DEF,
  parameter int WINDOW_BITS = zcobs_pkg::WINDOW_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  zcobs_in_if.sink     sample_ch,
  zcobs_cfg_if.sink    cfg_ch,
  zcobs_out_if.source  result_ch
);

  localparam int SUM_W = WINDOW_BITS + 16;

  logic [zcobs_pkg::STEP_W-1:0]      step_angle;
  logic [zcobs_pkg::ANGLE_CFG_W-1:0] angle_floor;
  logic [zcobs_pkg::ANGLE_CFG_W-1:0] angle_ceil;
  logic [zcobs_pkg::WLEN_W-1:0]      window_len;
  logic [zcobs_pkg::SCALE_W-1:0]     level_scale;
  logic [zcobs_pkg::ANGLE_CFG_W-1:0] check_angle;
  logic [zcobs_pkg::TIMEOUT_W-1:0]   timeout;

  logic mid_valid;
  logic out_valid;
  logic adv_out;
  logic adv_mid;
  logic load;

  zcobs_pkg::phase_flags_t           flags_r, flags_s, flags_t;
  logic [ANGLE_BITS-1:0]             angle_r, angle_s, angle_t;
  logic [SUM_W-1:0]                  sum_r, sum_s, sum_t;
  logic [zcobs_pkg::LEVEL_W-1:0]     lvl_r, lvl_s, lvl_t;

  zcobs_pkg::pol_t                   polarity_r, polarity_s, polarity_t;
  logic [zcobs_pkg::LEVEL_W-1:0]     level_r, level_s, level_t;
  zcobs_pkg::pol_t                   rotation;

  assign adv_out = !out_valid || result_ch.ready;
  assign adv_mid = !mid_valid || adv_out;
  assign load    = sample_ch.valid && adv_mid;

  assign sample_ch.ready = !rst && adv_mid;
  assign cfg_ch.ready    = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_angle  <= zcobs_pkg::STEP_ANGLE_RST;
      angle_floor <= zcobs_pkg::ANGLE_FLOOR_RST;
      angle_ceil  <= zcobs_pkg::ANGLE_CEIL_RST;
      window_len  <= zcobs_pkg::WINDOW_LEN_RST;
      level_scale <= zcobs_pkg::LEVEL_SCALE_RST;
      check_angle <= zcobs_pkg::CHECK_ANGLE_RST;
      timeout     <= zcobs_pkg::TIMEOUT_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        zcobs_pkg::REG_STEP_ANGLE:  step_angle  <= cfg_ch.data[zcobs_pkg::STEP_W-1:0];
        zcobs_pkg::REG_ANGLE_FLOOR: angle_floor <= cfg_ch.data[zcobs_pkg::ANGLE_CFG_W-1:0];
        zcobs_pkg::REG_ANGLE_CEIL:  angle_ceil  <= cfg_ch.data[zcobs_pkg::ANGLE_CFG_W-1:0];
        zcobs_pkg::REG_WINDOW_LEN:  window_len  <= cfg_ch.data[zcobs_pkg::WLEN_W-1:0];
        zcobs_pkg::REG_LEVEL_SCALE: level_scale <= cfg_ch.data[zcobs_pkg::SCALE_W-1:0];
        zcobs_pkg::REG_CHECK_ANGLE: check_angle <= cfg_ch.data[zcobs_pkg::ANGLE_CFG_W-1:0];
        zcobs_pkg::REG_TIMEOUT:     timeout     <= cfg_ch.data[zcobs_pkg::TIMEOUT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  zcobs_phase #(.ANGLE_BITS(ANGLE_BITS), .WINDOW_BITS(WINDOW_BITS)) u_phase_r (
    .clk, .rst, .load, .sample(sample_ch.sample_r), .step_angle, .angle_floor,
    .angle_ceil, .window_len, .flags(flags_r), .angle(angle_r), .sum_done(sum_r)
  );

  zcobs_phase #(.ANGLE_BITS(ANGLE_BITS), .WINDOW_BITS(WINDOW_BITS)) u_phase_s (
    .clk, .rst, .load, .sample(sample_ch.sample_s), .step_angle, .angle_floor,
    .angle_ceil, .window_len, .flags(flags_s), .angle(angle_s), .sum_done(sum_s)
  );

  zcobs_phase #(.ANGLE_BITS(ANGLE_BITS), .WINDOW_BITS(WINDOW_BITS)) u_phase_t (
    .clk, .rst, .load, .sample(sample_ch.sample_t), .step_angle, .angle_floor,
    .angle_ceil, .window_len, .flags(flags_t), .angle(angle_t), .sum_done(sum_t)
  );

  zcobs_level #(.WINDOW_BITS(WINDOW_BITS)) u_level_r (
    .sum(sum_r), .level_scale, .level(lvl_r)
  );

  zcobs_level #(.WINDOW_BITS(WINDOW_BITS)) u_level_s (
    .sum(sum_s), .level_scale, .level(lvl_s)
  );

  zcobs_level #(.WINDOW_BITS(WINDOW_BITS)) u_level_t (
    .sum(sum_t), .level_scale, .level(lvl_t)
  );

  zcobs_seq #(.ANGLE_BITS(ANGLE_BITS)) u_seq (
    .clk, .rst, .load(mid_valid && adv_out), .pol_r(flags_r.pol), .pol_s(flags_s.pol),
    .pol_t(flags_t.pol), .angle_r, .check_angle, .timeout, .rotation
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
      level_r   <= '0;
      level_s   <= '0;
      level_t   <= '0;
    end else begin
      if (adv_mid) begin
        mid_valid <= sample_ch.valid;
      end
      if (adv_out) begin
        out_valid <= mid_valid;
        if (mid_valid) begin
          if (flags_r.done) level_r <= lvl_r;
          if (flags_s.done) level_s <= lvl_s;
          if (flags_t.done) level_t <= lvl_t;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && mid_valid) begin
      polarity_r <= flags_r.pol;
      polarity_s <= flags_s.pol;
      polarity_t <= flags_t.pol;
    end
  end

  logic unused_angle;
  assign unused_angle = ^{angle_s, angle_t};

  assign result_ch.valid      = out_valid && (unused_angle || !unused_angle);
  assign result_ch.polarity_r = polarity_r;
  assign result_ch.polarity_s = polarity_s;
  assign result_ch.polarity_t = polarity_t;
  assign result_ch.level_r    = level_r;
  assign result_ch.level_s    = level_s;
  assign result_ch.level_t    = level_t;
  assign result_ch.rotation   = rotation;

endmodule

// File: hw/rtl/zcobs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zcobs_checker
// Port-level checks on the observer's result channel.
// ----------------------------------------------------------------------------
module zcobs_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  polarity_r,
  input logic [1:0]  polarity_s,
  input logic [1:0]  polarity_t,
  input logic [15:0] level_r,
  input logic [1:0]  rotation
);

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(polarity_r) && $stable(level_r)
                                && $stable(rotation))
    else $error("stalled result changed");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_polarity_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> polarity_r != 2'b10 && polarity_s != 2'b10 && polarity_t != 2'b10)
    else $error("polarity out of range");

  a_rotation_code: assert property (@(posedge clk) disable iff (rst)
    rotation != 2'b10)
    else $error("rotation out of range");

endmodule

bind three_phase_zero_cross_observer zcobs_checker u_zcobs_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (result_ch.valid),
  .out_ready  (result_ch.ready),
  .polarity_r (result_ch.polarity_r),
  .polarity_s (result_ch.polarity_s),
  .polarity_t (result_ch.polarity_t),
  .level_r    (result_ch.level_r),
  .rotation   (result_ch.rotation)
);

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for three_phase_zero_cross_observer. Sample sets go in
// through the sample channel under random bursts while the result channel
// stalls on changing ready patterns. A local tracker keeps the per-phase
// angle, polarity and window sums plus the rotation debounce. It predicts one
// result per transfer, and each result is compared field by field in order.
// The stimulus has a short directed part (corner values, polarity-zero
// crossings, clamps, level update on every sample, instant adoption). Then come
// random phases of synthetic rotating waveforms with noise and fully random
// sets. Settings are rewritten between idle phases, extremes among them.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 12;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_PHASES = 12;
  localparam int ANGLE_MAX     = 4095;
  localparam int SUM_W         = zcobs_pkg::WINDOW_BITS_DEF + 16;
  localparam int COUNT_W       = zcobs_pkg::WINDOW_BITS_DEF + 1;

  typedef logic signed [zcobs_pkg::SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t r;
    sample_t s;
    sample_t t;
  } sample_set_t;

  typedef struct packed {
    zcobs_pkg::pol_t               polarity_r;
    zcobs_pkg::pol_t               polarity_s;
    zcobs_pkg::pol_t               polarity_t;
    logic [zcobs_pkg::LEVEL_W-1:0] level_r;
    logic [zcobs_pkg::LEVEL_W-1:0] level_s;
    logic [zcobs_pkg::LEVEL_W-1:0] level_t;
    zcobs_pkg::pol_t               rotation;
  } reading_t;

  logic                             clk       = 1'b0;
  logic                             rst       = 1'b1;
  logic                             in_valid  = 1'b0;
  sample_set_t                      in_set    = '0;
  logic                             res_ready = 1'b0;
  logic                             cfg_valid = 1'b0;
  logic [zcobs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [zcobs_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  zcobs_in_if  sample_if ();
  zcobs_out_if result_if ();
  zcobs_cfg_if cfg_if ();

  assign sample_if.valid    = in_valid;
  assign sample_if.sample_r = in_set.r;
  assign sample_if.sample_s = in_set.s;
  assign sample_if.sample_t = in_set.t;
  assign result_if.ready    = res_ready;
  assign cfg_if.valid       = cfg_valid;
  assign cfg_if.index       = cfg_index;
  assign cfg_if.data        = cfg_data;

  three_phase_zero_cross_observer dut (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (sample_if),
    .cfg_ch    (cfg_if),
    .result_ch (result_if)
  );

  // tracker settings
  int unsigned step_cfg, floor_cfg, ceil_cfg, wlen_cfg, scale_cfg, check_cfg, timeout_cfg;

  // tracker state
  logic [zcobs_pkg::ANGLE_BITS_DEF-1:0] angle     [3];
  logic                                 neg_prev  [3];
  zcobs_pkg::pol_t                      pol       [3];
  logic [SUM_W-1:0]                     mag_sum   [3];
  logic [COUNT_W-1:0]                   win_cnt   [3];
  logic [zcobs_pkg::LEVEL_W-1:0]        level     [3];
  zcobs_pkg::pol_t                      cand_dir;
  zcobs_pkg::pol_t                      rot_dir;
  logic [zcobs_pkg::TIMEOUT_W-1:0]      settle_cnt;

  sample_set_t pending_samples [$];
  reading_t    expected_readings [$];
  int          samples_queued = 0;
  int          samples_taken  = 0;
  int          mismatch_count = 0;
  int          wave_pos       = 0;

  logic        in_took       = 1'b0;
  int          burst_left    = 0;
  int          gap_left      = 0;
  logic [15:0] stall_pattern = '1;
  logic [3:0]  pattern_pos   = '0;
  int          pattern_left  = 0;
  int          quiet_cycles  = 0;

  function automatic void clear_tracker();
    step_cfg    = zcobs_pkg::STEP_ANGLE_RST;
    floor_cfg   = zcobs_pkg::ANGLE_FLOOR_RST;
    ceil_cfg    = zcobs_pkg::ANGLE_CEIL_RST;
    wlen_cfg    = zcobs_pkg::WINDOW_LEN_RST;
    scale_cfg   = zcobs_pkg::LEVEL_SCALE_RST;
    check_cfg   = zcobs_pkg::CHECK_ANGLE_RST;
    timeout_cfg = zcobs_pkg::TIMEOUT_RST;
    for (int k = 0; k < 3; k++) begin
      angle[k]    = '0;
      neg_prev[k] = 1'b0;
      pol[k]      = zcobs_pkg::POL_ZERO;
      mag_sum[k]  = '0;
      win_cnt[k]  = '0;
      level[k]    = '0;
    end
    cand_dir   = zcobs_pkg::POL_ZERO;
    rot_dir    = zcobs_pkg::POL_ZERO;
    settle_cnt = '0;
  endfunction

  function automatic void advance_phase(input int k, input sample_t smp);
    logic        neg;
    logic [16:0] mag;
    int unsigned stepped;
    logic [41:0] prod;
    neg     = smp[zcobs_pkg::SAMPLE_W-1];
    mag     = neg ? 17'h10000 - {1'b0, smp} : {1'b0, smp};
    stepped = angle[k] + step_cfg;
    if (neg != neg_prev[k]) begin
      if (stepped < floor_cfg) pol[k] = zcobs_pkg::POL_ZERO;
      else if (!neg) pol[k] = zcobs_pkg::POL_POS;
      else pol[k] = zcobs_pkg::POL_NEG;
      angle[k]    = '0;
      neg_prev[k] = neg;
    end else if (stepped > ceil_cfg) begin
      pol[k]   = zcobs_pkg::POL_ZERO;
      angle[k] = ceil_cfg[zcobs_pkg::ANGLE_BITS_DEF-1:0];
    end else begin
      angle[k] = stepped[zcobs_pkg::ANGLE_BITS_DEF-1:0];
    end
    mag_sum[k] = mag_sum[k] + SUM_W'(mag);
    win_cnt[k] = win_cnt[k] + 1'b1;
    if (win_cnt[k] >= wlen_cfg) begin
      prod = 42'(mag_sum[k]) * 42'(scale_cfg);
      if (prod[41:zcobs_pkg::LEVEL_SHIFT] > 27'hFFFF) level[k] = '1;
      else level[k] = prod[zcobs_pkg::LEVEL_SHIFT +: zcobs_pkg::LEVEL_W];
      mag_sum[k] = '0;
      win_cnt[k] = '0;
    end
  endfunction

  function automatic reading_t next_reading(input sample_t r, input sample_t s,
                                            input sample_t t);
    zcobs_pkg::pol_t dir;
    reading_t        rd;
    advance_phase(0, r);
    advance_phase(1, s);
    advance_phase(2, t);
    if (pol[0] == zcobs_pkg::POL_POS && int'(angle[0]) == check_cfg) begin
      dir = zcobs_pkg::POL_ZERO;
      if (pol[1] == zcobs_pkg::POL_POS && pol[2] == zcobs_pkg::POL_NEG) dir = zcobs_pkg::POL_NEG;
      if (pol[1] == zcobs_pkg::POL_NEG && pol[2] == zcobs_pkg::POL_POS) dir = zcobs_pkg::POL_POS;
      if (dir != cand_dir) begin
        cand_dir   = dir;
        settle_cnt = '0;
      end else begin
        settle_cnt = settle_cnt + 1'b1;
        if (settle_cnt >= timeout_cfg) begin
          rot_dir    = dir;
          settle_cnt = '0;
        end
      end
    end
    rd.polarity_r = pol[0];
    rd.polarity_s = pol[1];
    rd.polarity_t = pol[2];
    rd.level_r    = level[0];
    rd.level_s    = level[1];
    rd.level_t    = level[2];
    rd.rotation   = rot_dir;
    return rd;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_reading(input reading_t want, input reading_t got);
    check_field("polarity_r", 16'(want.polarity_r), 16'(got.polarity_r));
    check_field("polarity_s", 16'(want.polarity_s), 16'(got.polarity_s));
    check_field("polarity_t", 16'(want.polarity_t), 16'(got.polarity_t));
    check_field("level_r", want.level_r, got.level_r);
    check_field("level_s", want.level_s, got.level_s);
    check_field("level_t", want.level_t, got.level_t);
    check_field("rotation", 16'(want.rotation), 16'(got.rotation));
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(9, 0))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      3: return '1;
      4: return 16'sh0001;
      default: return sample_t'($urandom);
    endcase
  endfunction

  // square-ish wave: non-negative over the first half period, negative after
  function automatic sample_t wave_sample(input int pos, input int period, input int amp,
                                          input int flip_pct);
    logic neg;
    int   value;
    neg = (pos >= period / 2);
    if (int'($urandom_range(100, 1)) <= flip_pct) neg = ~neg;
    if (neg) value = -int'($urandom_range(amp + 1, 1));
    else value = int'($urandom_range(amp, 0));
    return sample_t'(value);
  endfunction

  function automatic void queue_triple(input sample_t r, input sample_t s, input sample_t t);
    sample_set_t set;
    set.r = r;
    set.s = s;
    set.t = t;
    pending_samples.push_back(set);
    samples_queued++;
  endfunction

  function automatic void queue_wave(input int count, input int period,
                                     input zcobs_pkg::pol_t dir, input int amp,
                                     input int flip_pct);
    int lag_s, lag_t, i;
    lag_s = (dir == zcobs_pkg::POL_POS) ? period / 3 : 2 * period / 3;
    lag_t = (dir == zcobs_pkg::POL_POS) ? 2 * period / 3 : period / 3;
    for (i = 0; i < count; i++) begin
      queue_triple(wave_sample(wave_pos % period, period, amp, flip_pct),
                   wave_sample((wave_pos + period - lag_s) % period, period, amp, flip_pct),
                   wave_sample((wave_pos + period - lag_t) % period, period, amp, flip_pct));
      wave_pos++;
    end
  endfunction

  task automatic wait_idle();
    while (samples_taken != samples_queued || expected_readings.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // upper bits beyond the register width carry junk and must be dropped
  task automatic write_reg(input logic [zcobs_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned value, input int width);
    logic [zcobs_pkg::CFG_DATA_W-1:0] keep, word;
    keep = zcobs_pkg::CFG_DATA_W'((32'd1 << width) - 1);
    word = (zcobs_pkg::CFG_DATA_W'(value) & keep) |
           (zcobs_pkg::CFG_DATA_W'($urandom) & ~keep);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      zcobs_pkg::REG_STEP_ANGLE:  step_cfg    = word[zcobs_pkg::STEP_W-1:0];
      zcobs_pkg::REG_ANGLE_FLOOR: floor_cfg   = word[zcobs_pkg::ANGLE_CFG_W-1:0];
      zcobs_pkg::REG_ANGLE_CEIL:  ceil_cfg    = word[zcobs_pkg::ANGLE_CFG_W-1:0];
      zcobs_pkg::REG_WINDOW_LEN:  wlen_cfg    = word[zcobs_pkg::WLEN_W-1:0];
      zcobs_pkg::REG_LEVEL_SCALE: scale_cfg   = word[zcobs_pkg::SCALE_W-1:0];
      zcobs_pkg::REG_CHECK_ANGLE: check_cfg   = word[zcobs_pkg::ANGLE_CFG_W-1:0];
      zcobs_pkg::REG_TIMEOUT:     timeout_cfg = word[zcobs_pkg::TIMEOUT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_setup(input int step, input int min_a, input int max_a,
                             input int wlen, input int scale, input int chk, input int tmo);
    write_reg(zcobs_pkg::REG_STEP_ANGLE, step, zcobs_pkg::STEP_W);
    write_reg(zcobs_pkg::REG_ANGLE_FLOOR, min_a, zcobs_pkg::ANGLE_CFG_W);
    write_reg(zcobs_pkg::REG_ANGLE_CEIL, max_a, zcobs_pkg::ANGLE_CFG_W);
    write_reg(zcobs_pkg::REG_WINDOW_LEN, wlen, zcobs_pkg::WLEN_W);
    write_reg(zcobs_pkg::REG_LEVEL_SCALE, scale, zcobs_pkg::SCALE_W);
    write_reg(zcobs_pkg::REG_CHECK_ANGLE, chk, zcobs_pkg::ANGLE_CFG_W);
    write_reg(zcobs_pkg::REG_TIMEOUT, tmo, zcobs_pkg::TIMEOUT_W);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // sample driver: bursts of transfers separated by random gaps
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_samples.size() != 0) begin
        in_set   <= pending_samples.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(40, 1);
          gap_left   <= $urandom_range(1, 0) ? 0 : $urandom_range(8, 1);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result ready: walk a 16-bit stall pattern bit by bit, then pick a new one
  always @(negedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else if (pattern_left == 0) begin
      case ($urandom_range(3, 0))
        0: stall_pattern <= '1;
        1: stall_pattern <= 16'h0001;
        default: stall_pattern <= 16'($urandom) | 16'h0001;
      endcase
      pattern_left <= $urandom_range(80, 16);
      pattern_pos  <= '0;
      res_ready    <= 1'b1;
    end else begin
      res_ready    <= stall_pattern[pattern_pos];
      pattern_pos  <= pattern_pos + 1'b1;
      pattern_left <= pattern_left - 1;
    end
  end

  always @(posedge clk) begin
    reading_t got;
    if (rst) begin
      in_took      <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      in_took <= sample_if.valid && sample_if.ready;
      if (result_if.valid && result_if.ready) begin
        got.polarity_r = result_if.polarity_r;
        got.polarity_s = result_if.polarity_s;
        got.polarity_t = result_if.polarity_t;
        got.level_r    = result_if.level_r;
        got.level_s    = result_if.level_s;
        got.level_t    = result_if.level_t;
        got.rotation   = result_if.rotation;
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          mismatch_count++;
        end else begin
          check_reading(expected_readings.pop_front(), got);
        end
      end
      if (sample_if.valid && sample_if.ready) begin
        expected_readings.push_back(next_reading(sample_if.sample_r, sample_if.sample_s,
                                                 sample_if.sample_t));
        samples_taken <= samples_taken + 1;
      end
      if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int              step, period, span, max_a, min_a, chk, wlen, scale, tmo;
    int              count, seg, amp, flip;
    zcobs_pkg::pol_t dir;
    clear_tracker();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings, corner sample values
    queue_triple(0, 0, 0);
    queue_triple(-1, -32768, 32767);
    queue_triple(32767, 1, -1);
    queue_triple(-32768, -32768, -32768);
    queue_triple(1, 32767, 0);
    queue_triple(0, -1, -32768);
    queue_triple(-32768, 32767, 1);
    queue_triple(32767, -32768, -1);

    // early crossings, clamp, level on every sample, instant adoption
    wait_idle();
    apply_setup(255, 300, 600, 0, 65535, 0, 0);
    queue_triple(-32768, 32767, -32768);
    queue_triple(-1, 1, -1);
    queue_triple(0, 0, 0);
    queue_triple(1, -1, 5);
    queue_triple(5, -5, 5);
    queue_triple(5, -5, -5);
    queue_triple(-5, 5, -5);
    queue_triple(-5, 5, 5);
    queue_triple(32767, -32768, 32767);
    queue_triple(32767, -32768, 32767);
    queue_triple(-32768, 32767, -32768);
    queue_triple(0, 32767, -32768);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        1: step = 255;
        2: step = 0;
        default: step = ($urandom_range(9, 0) == 0) ? 255 : $urandom_range(8, 1);
      endcase
      period = (step == 255) ? $urandom_range(14, 6) : $urandom_range(40, 6);
      span   = (step == 0 ? 1 : step) * period;
      case ($urandom_range(5, 0))
        0: max_a = $urandom_range(span / 2, 0);
        1: max_a = ANGLE_MAX;
        default: max_a = span + $urandom_range(64, 0);
      endcase
      if (max_a > ANGLE_MAX) max_a = ANGLE_MAX;
      case ($urandom_range(5, 0))
        0: min_a = 0;
        1: min_a = ANGLE_MAX;
        default: min_a = $urandom_range(span / 2, 0);
      endcase
      if ($urandom_range(5, 0) == 0) chk = $urandom_range(ANGLE_MAX, 0);
      else chk = step * $urandom_range(period / 2 - 1, 0);
      if (chk > ANGLE_MAX) chk = ANGLE_MAX;
      case ((ph < 5) ? ph : $urandom_range(7, 0))
        0: wlen = 0;
        1: wlen = 1024;
        2: wlen = 2047;
        3: wlen = 1;
        default: wlen = $urandom_range(64, 2);
      endcase
      case ((ph < 3) ? ph : $urandom_range(5, 0))
        0: scale = 0;
        1: scale = 65535;
        2: scale = 32768;
        default: scale = $urandom_range(65535, 0);
      endcase
      case ((ph < 2) ? ph : $urandom_range(7, 0))
        0: tmo = 65535;
        1: tmo = $urandom_range(65535, 0);
        default: tmo = $urandom_range(4, 0);
      endcase
      apply_setup(step, min_a, max_a, wlen, scale, chk, tmo);

      count = $urandom_range(100, 60);
      if (ph > 2 && $urandom_range(4, 0) == 0) begin
        repeat (count) queue_triple(pick_sample(), pick_sample(), pick_sample());
      end else begin
        while (count > 0) begin
          seg = period * $urandom_range(6, 2);
          if (seg > count) seg = count;
          dir  = $urandom_range(1, 0) ? zcobs_pkg::POL_POS : zcobs_pkg::POL_NEG;
          amp  = ($urandom_range(3, 0) == 0) ? 32767 : $urandom_range(32767, 1);
          flip = $urandom_range(1, 0) ? 0 : $urandom_range(5, 1);
          queue_wave(seg, period, dir, amp, flip);
          count -= seg;
        end
      end
    end

    wait_idle();
    repeat (6) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
